/* rtl/core/first_fit_heap_allocator_unit_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the heap allocator
// Clocked property checks; empty when synthesizing.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FFHA_ASSERT(lbl, c, r, prop, msg) \
  lbl: assert property (@(posedge c) disable iff (r) prop) else $error(msg);
`define FFHA_NEVER(lbl, c, r, expr, msg) \
  lbl: assert property (@(posedge c) disable iff (r) !(expr)) else $error(msg);
`else
`define FFHA_ASSERT(lbl, c, r, prop, msg)
`define FFHA_NEVER(lbl, c, r, expr, msg)
`endif
`endif

/* rtl/core/ffha_pkg.sv */
// ---------------------------------------------------------------------------
// ffha_pkg
// Types and constants shared by the heap allocator modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffha_pkg;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic REG_HEAP_BASE = 1'b0;
  localparam logic REG_HEAP_SIZE = 1'b1;

  localparam logic [47:0] HEAP_BASE_RST = 48'd0;
  localparam logic [31:0] HEAP_SIZE_RST = 32'd1048576;

  localparam logic [32:0] ALIGN_LOW  = 33'd7;
  localparam logic [33:0] SPLIT_SLACK = 34'd8;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_OOM     = 3'd1,
    ST_ZERO    = 3'd2,
    ST_INVALID = 3'd3,
    ST_DOUBLE  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_HIT,
    S_RDP,
    S_RDN,
    S_NXT,
    S_SHIFT,
    S_WR_A,
    S_WR_B,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] length;
    logic        free;
  } seg_t;

  typedef struct packed {
    logic        opcode;
    logic [31:0] request_size;
    logic [47:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [47:0] data_address;
    logic [2:0]  status;
    logic [31:0] used_bytes;
    logic [31:0] free_bytes;
  } out_item_t;

endpackage

/* rtl/core/ffha_seg_mem.sv */
// ---------------------------------------------------------------------------
// ffha_seg_mem
// Segment table storage: one write port, one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffha_seg_mem import ffha_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  seg_t                     wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output seg_t                     rdata
);

  seg_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/ffha_ctrl.sv */
// ---------------------------------------------------------------------------
// ffha_ctrl
// Sequencer: first-fit scan, split, free with neighbor merge, table shifts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_unit_assert.svh"

module ffha_ctrl import ffha_pkg::*; #(
  parameter int MAX_SEGMENTS = 64,
  parameter int HEADER_BYTES = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            init_req,
  input  logic [47:0]                     heap_base,
  input  logic [31:0]                     heap_len,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  in_item_t                        in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output out_item_t                       out_data,
  output logic                            mem_we,
  output logic [$clog2(MAX_SEGMENTS)-1:0] mem_waddr,
  output seg_t                            mem_wdata,
  output logic [$clog2(MAX_SEGMENTS)-1:0] mem_raddr,
  input  seg_t                            mem_rdata
);

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);
  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] TWO  = CW'(2);
  localparam logic [31:0]   HDR  = 32'(HEADER_BYTES);

  ctrl_state_t state, state_next;

  logic          op;
  logic          req_zero;
  logic [32:0]   rounded;
  logic [47:0]   faddr;
  logic [31:0]   rel;
  logic [CW-1:0] scan_idx;
  logic          ex_valid;
  logic [CW-1:0] ex_idx;
  logic [CW-1:0] hit_idx;
  seg_t          hit_e;
  seg_t          prev_e;
  logic [CW-1:0] count;
  logic [31:0]   total;
  status_t       status;
  logic [47:0]   addr;
  logic [CW-1:0] sh_rd;
  logic [CW-1:0] sh_left;
  logic          sh_up;
  logic [1:0]    sh_dist;
  logic          rd_pend;
  logic [CW-1:0] rd_dst;
  logic          wa_pend;
  seg_t          wa_e;
  logic [CW-1:0] wa_idx;
  seg_t          wb_e;
  logic [CW-1:0] wb_idx;

  logic [31:0] avail;
  logic [48:0] low_bound;
  logic        below;
  logic [47:0] rel_wide;
  logic        outside;
  logic        scan_issue;
  logic        scan_hit;
  logic        split;
  logic        prev_ok;
  logic        next_ok;
  logic        out_load;

  assign avail      = (heap_len >= HDR) ? heap_len - HDR : 32'd0;
  assign low_bound  = {1'b0, heap_base} + 49'(HDR);
  assign below      = {1'b0, faddr} < low_bound;
  assign rel_wide   = faddr - heap_base - 48'(HDR);
  assign outside    = rel_wide >= {16'd0, heap_len};
  assign scan_issue = scan_idx < count;
  assign scan_hit   = ex_valid && ((op == OP_ALLOC) ?
                      (mem_rdata.free && (mem_rdata.length >= rounded[31:0])) :
                      (mem_rdata.offset == rel));
  assign split      = ({2'b0, hit_e.length} > ({1'b0, rounded} + 34'(HDR) + SPLIT_SLACK))
                      && (count < MAXC);
  assign prev_ok    = (hit_idx != '0) && prev_e.free;
  assign next_ok    = ((hit_idx + ONE) < count) && mem_rdata.free;
  assign out_load   = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = wb_e;
    mem_raddr  = scan_idx[IW-1:0];
    case (state)
      S_INIT: begin
        mem_we     = 1'b1;
        mem_wdata  = '{offset: 32'd0, length: avail, free: 1'b1};
        state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (op == OP_ALLOC) begin
          state_next = (req_zero || rounded[32]) ? S_DONE : S_SCAN;
        end else begin
          state_next = ((faddr == '0) || below || outside) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          state_next = S_HIT;
        end else if (ex_valid && (ex_idx == count - ONE)) begin
          state_next = S_DONE;
        end
      end
      S_HIT: begin
        if (op == OP_ALLOC) begin
          state_next = split ? S_SHIFT : S_WR_B;
        end else begin
          state_next = hit_e.free ? S_DONE : S_RDP;
        end
      end
      S_RDP: begin
        mem_raddr  = IW'(hit_idx - ONE);
        state_next = S_RDN;
      end
      S_RDN: begin
        mem_raddr  = IW'(hit_idx + ONE);
        state_next = S_NXT;
      end
      S_NXT: begin
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        mem_raddr = sh_rd[IW-1:0];
        if (rd_pend) begin
          mem_we    = 1'b1;
          mem_waddr = rd_dst[IW-1:0];
          mem_wdata = mem_rdata;
        end
        if ((sh_left == '0) && !rd_pend) begin
          state_next = wa_pend ? S_WR_A : S_WR_B;
        end
      end
      S_WR_A: begin
        mem_we     = 1'b1;
        mem_waddr  = wa_idx[IW-1:0];
        mem_wdata  = wa_e;
        state_next = S_WR_B;
      end
      S_WR_B: begin
        mem_we     = 1'b1;
        mem_waddr  = wb_idx[IW-1:0];
        mem_wdata  = wb_e;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
    if (init_req) begin
      state_next = S_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= ONE;
      total     <= '0;
      out_valid <= 1'b0;
      ex_valid  <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          count <= ONE;
          total <= '0;
        end
        S_SCAN: begin
          ex_valid <= scan_issue;
        end
        S_HIT: begin
          if (op == OP_ALLOC) begin
            total <= total + (split ? rounded[31:0] : hit_e.length);
            if (split) begin
              count <= count + ONE;
            end
          end else if (!hit_e.free) begin
            total <= total - hit_e.length;
          end
        end
        S_NXT: begin
          if (prev_ok && next_ok) begin
            count <= count - TWO;
          end else if (prev_ok || next_ok) begin
            count <= count - ONE;
          end
        end
        S_SHIFT: begin
          rd_pend <= sh_left != '0;
        end
        default: begin
          ex_valid <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.data_address <= addr;
      out_data.status       <= status;
      out_data.used_bytes   <= total;
      out_data.free_bytes   <= (avail > total) ? avail - total : 32'd0;
    end
    case (state)
      S_IDLE: begin
        op       <= in_data.opcode;
        req_zero <= in_data.request_size == '0;
        rounded  <= ({1'b0, in_data.request_size} + ALIGN_LOW) & ~ALIGN_LOW;
        faddr    <= in_data.free_address;
        addr     <= '0;
        status   <= ST_OK;
      end
      S_CHECK: begin
        scan_idx <= '0;
        rel      <= rel_wide[31:0];
        if (op == OP_ALLOC) begin
          if (req_zero) begin
            status <= ST_ZERO;
          end else if (rounded[32]) begin
            status <= ST_OOM;
          end
        end else if ((faddr != '0) && (below || outside)) begin
          status <= ST_INVALID;
        end
      end
      S_SCAN: begin
        ex_idx <= scan_idx;
        if (scan_issue) begin
          scan_idx <= scan_idx + ONE;
        end
        if (scan_hit) begin
          hit_idx <= ex_idx;
          hit_e   <= mem_rdata;
        end else if (ex_valid && (ex_idx == count - ONE)) begin
          status <= (op == OP_ALLOC) ? ST_OOM : ST_INVALID;
        end
      end
      S_HIT: begin
        sh_dist <= 2'd1;
        wb_idx  <= hit_idx;
        if (op == OP_ALLOC) begin
          addr    <= heap_base + 48'(hit_e.offset) + 48'(HDR);
          sh_up   <= 1'b1;
          sh_rd   <= count - ONE;
          sh_left <= count - hit_idx - ONE;
          wa_pend <= split;
          wa_idx  <= hit_idx + ONE;
          wa_e    <= '{offset: hit_e.offset + HDR + rounded[31:0],
                       length: hit_e.length - rounded[31:0] - HDR, free: 1'b1};
          wb_e    <= '{offset: hit_e.offset,
                       length: split ? rounded[31:0] : hit_e.length, free: 1'b0};
        end else if (hit_e.free) begin
          status <= ST_DOUBLE;
        end
      end
      S_RDN: begin
        prev_e <= mem_rdata;
      end
      S_NXT: begin
        sh_up   <= 1'b0;
        wa_pend <= 1'b0;
        case ({prev_ok, next_ok})
          2'b10: begin
            wb_e    <= '{offset: prev_e.offset,
                         length: prev_e.length + HDR + hit_e.length, free: 1'b1};
            wb_idx  <= hit_idx - ONE;
            sh_rd   <= hit_idx + ONE;
            sh_left <= count - hit_idx - ONE;
            sh_dist <= 2'd1;
          end
          2'b01: begin
            wb_e    <= '{offset: hit_e.offset,
                         length: hit_e.length + HDR + mem_rdata.length, free: 1'b1};
            wb_idx  <= hit_idx;
            sh_rd   <= hit_idx + TWO;
            sh_left <= count - hit_idx - TWO;
            sh_dist <= 2'd1;
          end
          2'b11: begin
            wb_e    <= '{offset: prev_e.offset,
                         length: prev_e.length + HDR + hit_e.length + HDR + mem_rdata.length,
                         free: 1'b1};
            wb_idx  <= hit_idx - ONE;
            sh_rd   <= hit_idx + TWO;
            sh_left <= count - hit_idx - TWO;
            sh_dist <= 2'd2;
          end
          default: begin
            wb_e    <= '{offset: hit_e.offset, length: hit_e.length, free: 1'b1};
            wb_idx  <= hit_idx;
            sh_left <= '0;
          end
        endcase
      end
      S_SHIFT: begin
        if (sh_left != '0) begin
          sh_left <= sh_left - ONE;
          sh_rd   <= sh_up ? sh_rd - ONE : sh_rd + ONE;
          rd_dst  <= sh_up ? sh_rd + ONE : sh_rd - CW'(sh_dist);
        end
      end
      default: begin
      end
    endcase
  end

  `FFHA_ASSERT(a_count_range, clk, rst, (count != '0) && (count <= MAXC), "segment count out of range")
  `FFHA_ASSERT(a_hit_in_table, clk, rst, (state == S_HIT) |-> (hit_idx < count), "hit beyond table")
  `FFHA_ASSERT(a_done_holds, clk, rst, (state == S_DONE && out_valid && !out_ready) |=> (state == S_DONE), "result overwrote pending beat")
  `FFHA_NEVER(a_fail_addr, clk, rst, (state == S_DONE) && (status != ST_OK) && (addr != '0), "address on failure")

endmodule

/* rtl/core/first_fit_heap_allocator_unit.sv */
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// First-fit heap allocator with split on allocate and merge on free.
// ---------------------------------------------------------------------------
//  channel   dir   beat
//  cfg       in    cfg_index (0 heap base, 1 heap length), cfg_data
//  in        in    in_item_t: opcode, request_size, free_address
//  out       out   out_item_t: data_address, status, used_bytes, free_bytes
//
//  One item at a time. Cost is dominated by the single table read port:
//  accept and check, a scan that reads the table entry by entry until a hit
//  or the last entry, a shift of the entries behind the hit when the table
//  grows or shrinks, reads of both neighbors on a free, 1..2 table writes,
//  then loading the result beat.
//  After reset or a heap length write, the init state rebuilds entry 0.
//  A waiting result holds the block in its last step until taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_heap_allocator_unit import ffha_pkg::*; #(
  parameter int MAX_SEGMENTS = 64,
  parameter int HEADER_BYTES = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  localparam int IW = $clog2(MAX_SEGMENTS);

  logic [47:0] heap_base;
  logic [31:0] heap_len;
  logic        init_req;
  logic        mem_we;
  logic [IW-1:0] mem_waddr;
  logic [IW-1:0] mem_raddr;
  seg_t        mem_wdata;
  seg_t        mem_rdata;

  assign cfg_ready = 1'b1;
  assign init_req  = cfg_valid && (cfg_index == REG_HEAP_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= HEAP_BASE_RST;
      heap_len  <= HEAP_SIZE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HEAP_BASE: heap_base <= cfg_data[47:0];
        REG_HEAP_SIZE: heap_len  <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  ffha_ctrl #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .init_req  (init_req),
    .heap_base (heap_base),
    .heap_len  (heap_len),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ffha_seg_mem #(
    .DEPTH(MAX_SEGMENTS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
